>>> hw/rtl/bct_pkg.sv
// shared types and character constants for the block comment tracker
`timescale 1ns / 1ps

package bct_pkg;

  // request kinds on the input channel
  typedef enum logic [1:0] {
    REQ_TEXT  = 2'd0,
    REQ_EOL   = 2'd1,
    REQ_CLEAR = 2'd2
  } req_type_e;

  // language selection register codes
  typedef enum logic [1:0] {
    LANG_NONE = 2'd0,
    LANG_C    = 2'd1,
    LANG_HTML = 2'd2
  } lang_e;

  // c-like scanner phase
  typedef enum logic [2:0] {
    PH_NORMAL    = 3'd0,
    PH_SLASH     = 3'd1,
    PH_STRING    = 3'd2,
    PH_ESCAPE    = 3'd3,
    PH_LINE_DONE = 3'd4
  } scan_phase_e;

  // characters of interest
  localparam logic [7:0] ChSlash  = 8'h2F;
  localparam logic [7:0] ChStar   = 8'h2A;
  localparam logic [7:0] ChDquote = 8'h22;
  localparam logic [7:0] ChSquote = 8'h27;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChLt     = 8'h3C;
  localparam logic [7:0] ChBang   = 8'h21;
  localparam logic [7:0] ChDash   = 8'h2D;
  localparam logic [7:0] ChGt     = 8'h3E;

  // one registered request
  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] text_byte;
  } bct_req_t;

  // one end of line result
  typedef struct packed {
    logic inside_comment;
    logic flag_changed;
  } bct_result_t;

endpackage

>>> hw/rtl/bct_scan.sv
// comment state registers and the per-request next state logic
`timescale 1ns / 1ps

module bct_scan (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  bct_pkg::bct_req_t  req_i,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_wdata_i,
  output bct_pkg::bct_result_t result_o
);

  logic                  comment_q, comment_d;
  logic                  start_q, start_d;
  bct_pkg::scan_phase_e  phase_q, phase_d;
  logic                  dquote_q, dquote_d;
  logic [1:0]            mark_q, mark_d;
  logic [1:0]            mode_q, mode_d;

  logic                  lang_on;
  logic                  fin;
  bct_pkg::scan_phase_e  plain_phase;
  logic                  plain_quote;
  logic [7:0]            b;
  logic [7:0]            close_quote;

  assign b           = req_i.text_byte;
  assign lang_on     = (mode_q == bct_pkg::LANG_C) || (mode_q == bct_pkg::LANG_HTML);
  assign fin         = lang_on & comment_q;
  assign close_quote = dquote_q ? bct_pkg::ChDquote : bct_pkg::ChSquote;

  // phase after a byte seen in plain text
  assign plain_quote = (b == bct_pkg::ChDquote) || (b == bct_pkg::ChSquote);
  always_comb begin
    if (b == bct_pkg::ChSlash) begin
      plain_phase = bct_pkg::PH_SLASH;
    end else if (plain_quote) begin
      plain_phase = bct_pkg::PH_STRING;
    end else begin
      plain_phase = bct_pkg::PH_NORMAL;
    end
  end

  // end of line result
  assign result_o.inside_comment = fin;
  assign result_o.flag_changed   = fin ^ start_q;

  // next state
  always_comb begin
    comment_d = comment_q;
    start_d   = start_q;
    phase_d   = phase_q;
    dquote_d  = dquote_q;
    mark_d    = mark_q;
    mode_d    = mode_q;

    if (step_i) begin
      unique case (req_i.req_type)
        bct_pkg::REQ_TEXT: begin
          unique case (mode_q)
            bct_pkg::LANG_C: begin
              if (comment_q) begin
                // look for star-slash
                if (b == bct_pkg::ChStar) begin
                  mark_d = 2'd1;
                end else if (b == bct_pkg::ChSlash && mark_q == 2'd1) begin
                  comment_d = 1'b0;
                  mark_d    = 2'd0;
                  phase_d   = bct_pkg::PH_NORMAL;
                end else begin
                  mark_d = 2'd0;
                end
              end else begin
                unique case (phase_q)
                  bct_pkg::PH_LINE_DONE: begin
                  end
                  bct_pkg::PH_STRING: begin
                    if (b == bct_pkg::ChBslash) begin
                      phase_d = bct_pkg::PH_ESCAPE;
                    end else if (b == close_quote) begin
                      phase_d = bct_pkg::PH_NORMAL;
                    end
                  end
                  bct_pkg::PH_ESCAPE: begin
                    phase_d = bct_pkg::PH_STRING;
                  end
                  bct_pkg::PH_SLASH: begin
                    if (b == bct_pkg::ChSlash) begin
                      phase_d = bct_pkg::PH_LINE_DONE;
                    end else if (b == bct_pkg::ChStar) begin
                      comment_d = 1'b1;
                      mark_d    = 2'd0;
                      phase_d   = bct_pkg::PH_NORMAL;
                    end else begin
                      phase_d = plain_phase;
                      if (plain_quote) begin
                        dquote_d = (b == bct_pkg::ChDquote);
                      end
                    end
                  end
                  default: begin
                    phase_d = plain_phase;
                    if (plain_quote) begin
                      dquote_d = (b == bct_pkg::ChDquote);
                    end
                  end
                endcase
              end
            end
            bct_pkg::LANG_HTML: begin
              if (comment_q) begin
                // look for dash dash gt
                if (b == bct_pkg::ChDash) begin
                  mark_d = (mark_q < 2'd2) ? mark_q + 2'd1 : 2'd2;
                end else if (b == bct_pkg::ChGt && mark_q == 2'd2) begin
                  comment_d = 1'b0;
                  mark_d    = 2'd0;
                end else begin
                  mark_d = 2'd0;
                end
              end else begin
                // look for lt bang dash dash
                if (b == bct_pkg::ChLt) begin
                  mark_d = 2'd1;
                end else if (b == bct_pkg::ChBang && mark_q == 2'd1) begin
                  mark_d = 2'd2;
                end else if (b == bct_pkg::ChDash && mark_q == 2'd2) begin
                  mark_d = 2'd3;
                end else if (b == bct_pkg::ChDash && mark_q == 2'd3) begin
                  comment_d = 1'b1;
                  mark_d    = 2'd0;
                end else begin
                  mark_d = 2'd0;
                end
              end
            end
            default: begin
            end
          endcase
        end
        bct_pkg::REQ_EOL: begin
          comment_d = fin;
          start_d   = fin;
          phase_d   = bct_pkg::PH_NORMAL;
          mark_d    = 2'd0;
        end
        bct_pkg::REQ_CLEAR: begin
          comment_d = 1'b0;
          start_d   = 1'b0;
          phase_d   = bct_pkg::PH_NORMAL;
          mark_d    = 2'd0;
        end
        default: begin
        end
      endcase
    end

    // language write restarts the line scan
    if (cfg_we_i) begin
      mode_d  = cfg_wdata_i;
      phase_d = bct_pkg::PH_NORMAL;
      mark_d  = 2'd0;
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      comment_q <= 1'b0;
      start_q   <= 1'b0;
      phase_q   <= bct_pkg::PH_NORMAL;
      dquote_q  <= 1'b0;
      mark_q    <= 2'd0;
      mode_q    <= bct_pkg::LANG_NONE;
    end else begin
      comment_q <= comment_d;
      start_q   <= start_d;
      phase_q   <= phase_d;
      dquote_q  <= dquote_d;
      mark_q    <= mark_d;
      mode_q    <= mode_d;
    end
  end

endmodule

>>> hw/rtl/bct_out_reg.sv
// result register with valid and ready toward the receiver
`timescale 1ns / 1ps

module bct_out_reg (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  bct_pkg::bct_result_t data_i,
  output logic                 can_load_o,
  output logic                 valid_o,
  input  logic                 ready_i,
  output bct_pkg::bct_result_t data_o
);

  logic                 valid_q, valid_d;
  bct_pkg::bct_result_t data_q;

  assign can_load_o = !valid_q || ready_i;

  // valid tracking
  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

>>> hw/rtl/block_comment_tracker_unit.sv
// top level of the block comment tracker
`timescale 1ns / 1ps

// Tracks whether source text is inside a block comment, one byte per request.
// Input channel (in_valid_i / in_ready_o) carries req_type_i and text_byte_i:
// a text byte, an end of line, or a clear of the comment state.
// Output channel (out_valid_o / out_ready_i) gives one result per end of
// line: inside_comment_o and flag_changed_o. Other requests give no result.
// cfg_we_i / cfg_wdata_i set the language (none, c-like, html) with no wait;
// write only while no request is in flight.
// An end of line request accepted at the input is registered there, then
// updates the state and loads the result register as it advances; that
// register drives the output. Throughput is one request per cycle while no
// end of line is held back, with the state update between the two registers.
// When the receiver stalls, text and clear requests keep flowing; an end of
// line waits in the input register only while the result register is full
// and not being taken, which then holds off the input.
// Reset clears the comment state, the language (to none) and both valids.

module block_comment_tracker_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] req_type_i,
  input  logic [7:0] text_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       inside_comment_o,
  output logic       flag_changed_o,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_wdata_i
);

  logic                 in_valid_q;
  bct_pkg::bct_req_t    in_req_q;
  logic                 out_can_load;
  logic                 is_eol;
  logic                 advance;
  bct_pkg::bct_result_t result;
  bct_pkg::bct_result_t out_data;

  // input register advances unless an end of line is blocked by the output
  assign is_eol     = (in_req_q.req_type == bct_pkg::REQ_EOL);
  assign advance    = in_valid_q && (!is_eol || out_can_load);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_req_q.req_type  <= req_type_i;
      in_req_q.text_byte <= text_byte_i;
    end
  end

  // comment state update
  bct_scan u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .req_i       (in_req_q),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .result_o    (result)
  );

  // result register
  bct_out_reg u_out_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (advance && is_eol),
    .data_i     (result),
    .can_load_o (out_can_load),
    .valid_o    (out_valid_o),
    .ready_i    (out_ready_i),
    .data_o     (out_data)
  );

  assign inside_comment_o = out_data.inside_comment;
  assign flag_changed_o   = out_data.flag_changed;

  // a result only ever comes from an end of line request
  a_result_from_eol: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_q && is_eol))
    else $error("result raised without an end of line request");

  // the input is held off only by a full, stalled result register
  a_stall_reason: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !in_ready_o) |-> (is_eol && out_valid_o && !out_ready_i))
    else $error("input stalled without a blocked result");

  // a blocked end of line keeps its place in the input register
  a_eol_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && is_eol && !advance) |=> (in_valid_q && is_eol))
    else $error("stalled end of line request lost");

endmodule

>>> tb/sv/tb_block_comment_tracker_unit.sv
// self-checking testbench for the block comment tracker with a line result scoreboard
`timescale 1ns / 1ps

module tb_block_comment_tracker_unit;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned PhaseItems = 100;
  localparam int unsigned NumPhases  = 8;
  localparam logic [1:0]  LangUnused = 2'd3;
  localparam logic [1:0]  ReqUnused  = 2'd3;

  // tracks comment state per line and keeps the expected end of line flags
  class eol_scoreboard;
    logic [1:0]           lang;
    logic                 comment_open;
    logic                 line_start;
    logic                 quote_dq;
    bct_pkg::scan_phase_e phase;
    logic [1:0]           mprog;
    bct_pkg::bct_result_t eol_flags_q[$];
    int                   errors;
    int                   lines_checked;

    function new();
      lang          = bct_pkg::LANG_NONE;
      comment_open  = 1'b0;
      line_start    = 1'b0;
      quote_dq      = 1'b0;
      phase         = bct_pkg::PH_NORMAL;
      mprog         = 2'd0;
      errors        = 0;
      lines_checked = 0;
    endfunction

    task report(input string what);
      errors++;
      $display("[%0t] mismatch: %s", $time, what);
    endtask

    function int pending();
      return eol_flags_q.size();
    endfunction

    // a language write drops any partial marker or string scan
    function void set_language(input logic [1:0] value);
      lang  = value;
      phase = bct_pkg::PH_NORMAL;
      mprog = 2'd0;
    endfunction

    // ordinary c text: may start a slash or a quoted string
    function void c_plain(input logic [7:0] b);
      if (b == bct_pkg::ChSlash) begin
        phase = bct_pkg::PH_SLASH;
      end else if (b == bct_pkg::ChDquote || b == bct_pkg::ChSquote) begin
        phase    = bct_pkg::PH_STRING;
        quote_dq = (b == bct_pkg::ChDquote);
      end else begin
        phase = bct_pkg::PH_NORMAL;
      end
    endfunction

    function void c_text(input logic [7:0] b);
      if (comment_open) begin
        if (b == bct_pkg::ChStar) begin
          mprog = 2'd1;
        end else if (b == bct_pkg::ChSlash && mprog == 2'd1) begin
          comment_open = 1'b0;
          mprog        = 2'd0;
          phase        = bct_pkg::PH_NORMAL;
        end else begin
          mprog = 2'd0;
        end
      end else begin
        unique case (phase)
          bct_pkg::PH_LINE_DONE: begin
          end
          bct_pkg::PH_STRING: begin
            if (b == bct_pkg::ChBslash) phase = bct_pkg::PH_ESCAPE;
            else if (b == (quote_dq ? bct_pkg::ChDquote : bct_pkg::ChSquote))
              phase = bct_pkg::PH_NORMAL;
          end
          bct_pkg::PH_ESCAPE: phase = bct_pkg::PH_STRING;
          bct_pkg::PH_SLASH: begin
            if (b == bct_pkg::ChSlash) begin
              phase = bct_pkg::PH_LINE_DONE;
            end else if (b == bct_pkg::ChStar) begin
              comment_open = 1'b1;
              mprog        = 2'd0;
              phase        = bct_pkg::PH_NORMAL;
            end else begin
              c_plain(b);
            end
          end
          default: c_plain(b);
        endcase
      end
    endfunction

    function void html_text(input logic [7:0] b);
      if (comment_open) begin
        if (b == bct_pkg::ChDash) begin
          mprog = (mprog < 2'd2) ? mprog + 2'd1 : 2'd2;
        end else if (b == bct_pkg::ChGt && mprog == 2'd2) begin
          comment_open = 1'b0;
          mprog        = 2'd0;
        end else begin
          mprog = 2'd0;
        end
      end else begin
        if (b == bct_pkg::ChLt) mprog = 2'd1;
        else if (b == bct_pkg::ChBang && mprog == 2'd1) mprog = 2'd2;
        else if (b == bct_pkg::ChDash && mprog == 2'd2) mprog = 2'd3;
        else if (b == bct_pkg::ChDash && mprog == 2'd3) begin
          comment_open = 1'b1;
          mprog        = 2'd0;
        end else mprog = 2'd0;
      end
    endfunction

    // advance the state for one accepted request
    function void note_request(input logic [1:0] req, input logic [7:0] b);
      bct_pkg::bct_result_t res;
      logic                 fin;
      unique case (req)
        bct_pkg::REQ_TEXT: begin
          if (lang == bct_pkg::LANG_C) c_text(b);
          else if (lang == bct_pkg::LANG_HTML) html_text(b);
        end
        bct_pkg::REQ_EOL: begin
          fin = (lang == bct_pkg::LANG_C || lang == bct_pkg::LANG_HTML) ?
                comment_open : 1'b0;
          res.inside_comment = fin;
          res.flag_changed   = fin ^ line_start;
          eol_flags_q        = {eol_flags_q, res};
          comment_open = fin;
          line_start   = fin;
          phase        = bct_pkg::PH_NORMAL;
          mprog        = 2'd0;
        end
        bct_pkg::REQ_CLEAR: begin
          comment_open = 1'b0;
          line_start   = 1'b0;
          phase        = bct_pkg::PH_NORMAL;
          mprog        = 2'd0;
        end
        default: begin
        end
      endcase
    endfunction

    // compare one accepted line result with the oldest expectation
    task check_result(input logic got_in, input logic changed);
      bct_pkg::bct_result_t want;
      if (eol_flags_q.size() == 0) begin
        report($sformatf("line result %0b/%0b with nothing expected", got_in, changed));
      end else begin
        want = eol_flags_q.pop_front();
        lines_checked++;
        if (got_in !== want.inside_comment)
          report($sformatf("inside_comment %0b, expected %0b", got_in,
                           want.inside_comment));
        if (changed !== want.flag_changed)
          report($sformatf("flag_changed %0b, expected %0b", changed, want.flag_changed));
      end
    endtask
  endclass

  logic       clk_i;
  logic       rst_ni    = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_ready;
  logic [1:0] req_type  = bct_pkg::REQ_TEXT;
  logic [7:0] text_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       inside_comment;
  logic       flag_changed;
  logic       cfg_we    = 1'b0;
  logic [1:0] cfg_wdata = bct_pkg::LANG_NONE;

  eol_scoreboard sb;
  int unsigned   cycles      = 0;
  int unsigned   items_sent  = 0;
  int unsigned   lang_writes = 0;
  int unsigned   phase_end;
  bit            no_gaps     = 1'b0;
  bit            hold_go     = 1'b0;
  bit            hold_done   = 1'b0;
  bit            pause_done  = 1'b0;
  logic [1:0]    phase_langs [NumPhases];

  block_comment_tracker_unit uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .req_type_i       (req_type),
    .text_byte_i      (text_byte),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .inside_comment_o (inside_comment),
    .flag_changed_o   (flag_changed),
    .cfg_we_i         (cfg_we),
    .cfg_wdata_i      (cfg_wdata)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, sb.pending());
      $display("tb_block_comment_tracker_unit: done, errors");
      $finish;
    end
  end

  // watch both channels and the language register
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid && out_ready) sb.check_result(inside_comment, flag_changed);
      if (cfg_we) sb.set_language(cfg_wdata);
      if (in_valid && in_ready) sb.note_request(req_type, text_byte);
    end
  end

  // receiver: random stalls, one long hold-off on request
  initial begin : receiver
    int unsigned held;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_go) begin
        hold_go = 1'b0;
        out_ready <= 1'b0;
        held = 0;
        while (held < HoldCycles) begin
          @(posedge clk_i);
          held++;
        end
      end else if (!no_gaps && $urandom_range(99) < 7) begin
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // offer one request and wait until it is taken
  task automatic send_item(input logic [1:0] req, input logic [7:0] b);
    if (!no_gaps && $urandom_range(99) < 7) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid  <= 1'b1;
    req_type  <= req;
    text_byte <= b;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    if (req != ReqUnused) items_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(bct_pkg::REQ_TEXT, s[i]);
  endtask

  task automatic send_eol();
    send_item(bct_pkg::REQ_EOL, 8'($urandom_range(255)));
  endtask

  // stop offering until every line result is back and the pipe has drained
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_language(input logic [1:0] value);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    lang_writes++;
  endtask

  // one lexical piece biased toward the markers of the language
  task automatic send_token(input logic [1:0] lang);
    int unsigned pick;
    pick = $urandom_range(0, 13);
    if (lang == bct_pkg::LANG_HTML) begin
      unique case (pick)
        0, 1:    send_text("<!--");
        2, 3:    send_text("-->");
        4:       send_text("-");
        5:       send_text("<");
        6:       send_text("!");
        7:       send_text(">");
        8:       send_text("<!-");
        9:       send_text("--");
        default: send_item(bct_pkg::REQ_TEXT, 8'($urandom_range(255)));
      endcase
    end else begin
      unique case (pick)
        0, 1:    send_text("/*");
        2, 3:    send_text("*/");
        4:       send_text("//");
        5:       send_text("\"");
        6:       send_text("'");
        7:       send_text("\\");
        8:       send_text("/");
        9:       send_text("*");
        10:      send_text("\\\"");
        default: send_item(bct_pkg::REQ_TEXT, 8'($urandom_range(255)));
      endcase
    end
  endtask

  // a line of random pieces with the odd clear or unused request mixed in
  task automatic send_line(input logic [1:0] lang);
    int unsigned n;
    n = $urandom_range(0, 8);
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(99) < 3) send_item(bct_pkg::REQ_CLEAR, 8'($urandom_range(255)));
      else if ($urandom_range(99) < 2) send_item(ReqUnused, 8'($urandom_range(255)));
      else send_token(lang);
    end
    send_eol();
  endtask

  // stimulus
  initial begin
    sb = new();
    phase_langs = '{bct_pkg::LANG_C, bct_pkg::LANG_HTML, bct_pkg::LANG_C,
                    bct_pkg::LANG_NONE, bct_pkg::LANG_HTML, LangUnused, bct_pkg::LANG_C,
                    bct_pkg::LANG_HTML};
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // c-like: open, close, string with trailing backslash, line comment, lone slash
    set_language(bct_pkg::LANG_C);
    send_text("/*");
    send_eol();
    send_text("*/");
    send_eol();
    send_text("\"\\");
    send_eol();
    send_text("//*");
    send_eol();
    send_text("/");
    send_eol();

    // html: open, clear while open, language rewrite in the middle of a marker
    set_language(bct_pkg::LANG_HTML);
    send_text("<!--");
    send_eol();
    send_item(bct_pkg::REQ_CLEAR, 8'h00);
    send_eol();
    send_text("<!");
    set_language(bct_pkg::LANG_HTML);
    send_text("--");
    send_eol();

    // the unused language code, which acts as no language, and the unused request code
    set_language(LangUnused);
    send_item(bct_pkg::REQ_TEXT, 8'hFF);
    send_item(ReqUnused, 8'hFF);
    send_item(bct_pkg::REQ_TEXT, 8'h00);
    send_eol();

    // random phases, one per language setting
    for (int ph = 0; ph < NumPhases; ph++) begin
      set_language(phase_langs[ph]);
      no_gaps   = (ph == 1);
      phase_end = items_sent + PhaseItems;
      while (items_sent < phase_end) begin
        if (ph == 0 && !hold_done && items_sent + 70 > phase_end) begin
          hold_go   = 1'b1;
          hold_done = 1'b1;
        end
        if (ph == 4 && !pause_done && items_sent + 50 > phase_end) begin
          wait_idle();
          pause_done = 1'b1;
        end
        send_line(phase_langs[ph]);
      end
      // leave a partial line so the next write lands mid-line
      repeat ($urandom_range(0, 2)) send_token(phase_langs[ph]);
    end
    no_gaps = 1'b0;

    // drain
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("covered %0d requests and %0d line results over %0d language writes",
             items_sent, sb.lines_checked, lang_writes);
    $display("modes none, c-like, html and the unused code, with a long output hold-off");
    if (sb.errors == 0) begin
      $display("tb_block_comment_tracker_unit: done, clean");
    end else begin
      $display("tb_block_comment_tracker_unit: done, errors");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/bct_pkg.sv
hw/rtl/bct_scan.sv
hw/rtl/bct_out_reg.sv
hw/rtl/block_comment_tracker_unit.sv
tb/sv/tb_block_comment_tracker_unit.sv
